### hdl/cbit_pkg.sv
// Shared constants, codes and types for the counted block index table.
// No dependencies; imported by every module in this folder.
package cbit_pkg;

    localparam int MAX_BLOCKS = 64;
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
    localparam int DATA_W     = 32;
    localparam int LIMIT_W    = 7;
    localparam int ACT_W      = 2;
    localparam int ST_W       = 2;
    localparam int POS_W      = 6;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

    typedef enum logic [ACT_W-1:0] {
        ACT_INSERT = 2'd0,
        ACT_LOCATE = 2'd1,
        ACT_SET    = 2'd2,
        ACT_ALLOC  = 2'd3
    } t_action;

    typedef enum logic [ST_W-1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_RANGE    = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    typedef struct packed {
        logic [DATA_W-1:0] count;
        logic [DATA_W-1:0] address;
    } t_entry;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        t_entry           data;
    } t_ram_wr;

endpackage

### hdl/cbit_entry_ram.sv
// Entry store: one write port, one registered read port.
// Depends on cbit_pkg for depth and entry layout.
module cbit_entry_ram (
    input  logic                        i_clk,
    input  cbit_pkg::t_ram_wr           i_wr,
    input  logic [cbit_pkg::IDX_W-1:0]  i_raddr,
    output cbit_pkg::t_entry            o_rdata
);
    import cbit_pkg::*;

    t_entry r_mem [MAX_BLOCKS];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/cbit_sub_unit.sv
// Subtract/compare unit used by the locate walk.
// Depends on cbit_pkg for the data width.
module cbit_sub_unit (
    input  logic [cbit_pkg::DATA_W-1:0] i_a,
    input  logic [cbit_pkg::DATA_W-1:0] i_b,
    output logic [cbit_pkg::DATA_W-1:0] o_diff,
    output logic                        o_borrow
);
    import cbit_pkg::*;

    logic [DATA_W:0] diff_ext;

    assign diff_ext = {1'b0, i_a} - {1'b0, i_b};
    assign o_diff   = diff_ext[DATA_W-1:0];
    assign o_borrow = diff_ext[DATA_W];

endmodule

### hdl/counted_block_index_table.sv
// Counted block index table: sequencer, counters, result register.
// Set entry, allocate and a refused insert register their word at the accepting edge; an insert
// first shifts the entries at and above the position up one place, a locate walks the entries
// from 0 until the target falls inside one or the live entries end. One item at a time;
// the next start is taken at the edge that ends the word's cycle; the receiver cannot stall.
// Sync active-low reset clears counters and sets the limit to 64; entries stay unset.
module counted_block_index_table (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [cbit_pkg::ACT_W-1:0]    i_action,
    input  logic [cbit_pkg::DATA_W-1:0]   i_target,
    input  logic [cbit_pkg::DATA_W-1:0]   i_new_count,
    input  logic [cbit_pkg::DATA_W-1:0]   i_new_address,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [cbit_pkg::LIMIT_W-1:0]  i_cfg_block_limit,
    output logic                          o_valid,
    output logic [cbit_pkg::ST_W-1:0]     o_status,
    output logic [cbit_pkg::POS_W-1:0]    o_block_position,
    output logic [cbit_pkg::DATA_W-1:0]   o_block_count,
    output logic [cbit_pkg::DATA_W-1:0]   o_block_address,
    output logic [cbit_pkg::DATA_W-1:0]   o_area_number
);
    import cbit_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_INS  = 3'b010,
        S_LOC  = 3'b100
    } t_state;

    t_state              r_state,  n_state;
    logic [CNT_W-1:0]    r_live,   n_live;
    logic [DATA_W-1:0]   r_area,   n_area;
    logic [LIMIT_W-1:0]  r_limit,  n_limit;
    logic [CNT_W-1:0]    r_tpos,   n_tpos;
    logic [CNT_W-1:0]    r_ptr,    n_ptr;
    logic                r_pend,   n_pend;
    logic [IDX_W-1:0]    r_waddr,  n_waddr;
    logic [IDX_W-1:0]    r_cidx,   n_cidx;
    logic [DATA_W-1:0]   r_rest,   n_rest;
    logic                r_valid,  n_valid;
    t_status             r_status, n_status;
    logic [POS_W-1:0]    r_pos,    n_pos;
    logic [DATA_W-1:0]   r_cnt,    n_cnt;
    logic [DATA_W-1:0]   r_addr,   n_addr;
    logic [DATA_W-1:0]   r_anum,   n_anum;

    t_ram_wr             wr;
    logic [IDX_W-1:0]    rd_addr;
    t_entry              rd_data;
    logic [DATA_W-1:0]   sub_diff;
    logic                sub_borrow;
    logic [DATA_W-1:0]   live_ext;
    logic                tbl_full;
    logic                ins_issue;
    logic                loc_issue;
    logic [CNT_W-1:0]    ptr_dec;

    cbit_entry_ram u_ram (
        .i_clk   (i_clk),
        .i_wr    (wr),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    cbit_sub_unit u_sub (
        .i_a      (r_rest),
        .i_b      (rd_data.count),
        .o_diff   (sub_diff),
        .o_borrow (sub_borrow)
    );

    assign live_ext  = DATA_W'(r_live);
    assign tbl_full  = (live_ext >= DATA_W'(r_limit)) || (live_ext >= DATA_W'(MAX_BLOCKS));
    assign ptr_dec   = r_ptr - CNT_W'(1);
    assign ins_issue = (r_ptr > r_tpos);
    assign loc_issue = (r_ptr < r_live);

    always_comb begin
        n_state  = r_state;
        n_live   = r_live;
        n_area   = r_area;
        n_limit  = r_limit;
        n_tpos   = r_tpos;
        n_ptr    = r_ptr;
        n_pend   = r_pend;
        n_waddr  = r_waddr;
        n_cidx   = r_cidx;
        n_rest   = r_rest;
        n_valid  = 1'b0;
        n_status = r_status;
        n_pos    = r_pos;
        n_cnt    = r_cnt;
        n_addr   = r_addr;
        n_anum   = r_anum;
        wr       = '0;
        rd_addr  = r_ptr[IDX_W-1:0];

        if (i_cfg_valid) begin
            n_limit = i_cfg_block_limit;
        end

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_status = ST_OK;
                    n_pos    = '0;
                    n_cnt    = '0;
                    n_addr   = '0;
                    n_anum   = '0;
                    unique case (t_action'(i_action))
                        ACT_INSERT: begin
                            if (tbl_full) begin
                                n_status = ST_FULL;
                                n_valid  = 1'b1;
                            end else if (i_target > live_ext) begin
                                n_status = ST_RANGE;
                                n_valid  = 1'b1;
                            end else begin
                                n_tpos  = CNT_W'(i_target);
                                n_ptr   = r_live;
                                n_pend  = 1'b0;
                                n_state = S_INS;
                            end
                        end
                        ACT_LOCATE: begin
                            n_rest  = i_target;
                            n_ptr   = '0;
                            n_pend  = 1'b0;
                            n_state = S_LOC;
                        end
                        ACT_SET: begin
                            n_valid = 1'b1;
                            if (i_target >= live_ext) begin
                                n_status = ST_RANGE;
                            end else begin
                                wr.en           = 1'b1;
                                wr.addr         = IDX_W'(i_target);
                                wr.data.count   = i_new_count;
                                wr.data.address = i_new_address;
                                n_pos           = POS_W'(i_target);
                                n_cnt           = i_new_count;
                                n_addr          = i_new_address;
                            end
                        end
                        ACT_ALLOC: begin
                            n_valid = 1'b1;
                            n_anum  = r_area;
                            n_area  = r_area + DATA_W'(1);
                        end
                        default: ;
                    endcase
                end
            end

            S_INS: begin
                // shift walk: read entry below, write it one place up next cycle
                rd_addr = ptr_dec[IDX_W-1:0];
                if (r_pend) begin
                    wr.en   = 1'b1;
                    wr.addr = r_waddr;
                    wr.data = rd_data;
                end
                if (ins_issue) begin
                    n_ptr   = ptr_dec;
                    n_pend  = 1'b1;
                    n_waddr = r_ptr[IDX_W-1:0];
                end else begin
                    n_pend = 1'b0;
                end
                if (!ins_issue && !r_pend) begin
                    wr.en   = 1'b1;
                    wr.addr = r_tpos[IDX_W-1:0];
                    wr.data = '0;
                    n_live  = r_live + CNT_W'(1);
                    n_pos   = POS_W'(r_tpos);
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end

            S_LOC: begin
                rd_addr = r_ptr[IDX_W-1:0];
                if (loc_issue) begin
                    n_ptr  = r_ptr + CNT_W'(1);
                    n_pend = 1'b1;
                    n_cidx = r_ptr[IDX_W-1:0];
                end else begin
                    n_pend = 1'b0;
                end
                if (r_pend) begin
                    if (sub_borrow) begin
                        n_pos   = POS_W'(r_cidx);
                        n_cnt   = rd_data.count;
                        n_addr  = rd_data.address;
                        n_valid = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_rest = sub_diff;
                    end
                end else if (!loc_issue) begin
                    n_status = ST_NOTFOUND;
                    n_valid  = 1'b1;
                    n_state  = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_live  <= '0;
            r_area  <= '0;
            r_limit <= LIMIT_RESET;
            r_pend  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_live  <= n_live;
            r_area  <= n_area;
            r_limit <= n_limit;
            r_pend  <= n_pend;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tpos   <= n_tpos;
        r_ptr    <= n_ptr;
        r_waddr  <= n_waddr;
        r_cidx   <= n_cidx;
        r_rest   <= n_rest;
        r_status <= n_status;
        r_pos    <= n_pos;
        r_cnt    <= n_cnt;
        r_addr   <= n_addr;
        r_anum   <= n_anum;
    end

    assign busy             = (r_state != S_IDLE);
    assign o_cfg_ready      = 1'b1;
    assign o_valid          = r_valid;
    assign o_status         = r_status;
    assign o_block_position = r_pos;
    assign o_block_count    = r_cnt;
    assign o_block_address  = r_addr;
    assign o_area_number    = r_anum;

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result word while sequencer busy");

    a_live_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_live <= CNT_W'(MAX_BLOCKS))
        else $error("live entry count above capacity");

    a_busy_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start))
        else $error("sequencer left idle without start");

    a_live_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_live != $past(r_live))) |->
        (o_valid && (o_status == ST_OK) && (r_live == $past(r_live) + CNT_W'(1))))
        else $error("live entry count changed without a good insert");

endmodule

### test/tb_counted_block_index_table.sv
`timescale 1ns / 100ps
// Self-checking bench for counted_block_index_table: a directed table, then random words
// checked against an in-bench predictor of the entry table. Depends on cbit_pkg and the RTL.
module tb_counted_block_index_table;
    import cbit_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_WORDS = 2000;
    localparam int PHASES       = 7;

    typedef struct packed {
        t_status           status;
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] count;
        logic [DATA_W-1:0] address;
        logic [DATA_W-1:0] area;
    } t_word;

    typedef enum logic {ROW_WORD, ROW_LIMIT} t_row_kind;

    typedef struct {
        t_row_kind         kind;
        t_action           act;
        logic [DATA_W-1:0] target;
        logic [DATA_W-1:0] count;
        logic [DATA_W-1:0] address;
        bit                typed;
        t_word             expected;
    } t_row;

    logic                i_clk             = 1'b0;
    logic                i_rst_n           = 1'b0;
    logic                start             = 1'b0;
    logic                busy;
    logic [ACT_W-1:0]    i_action          = '0;
    logic [DATA_W-1:0]   i_target          = '0;
    logic [DATA_W-1:0]   i_new_count       = '0;
    logic [DATA_W-1:0]   i_new_address     = '0;
    logic                i_cfg_valid       = 1'b0;
    logic                o_cfg_ready;
    logic [LIMIT_W-1:0]  i_cfg_block_limit = LIMIT_RESET;
    logic                o_valid;
    logic [ST_W-1:0]     o_status;
    logic [POS_W-1:0]    o_block_position;
    logic [DATA_W-1:0]   o_block_count;
    logic [DATA_W-1:0]   o_block_address;
    logic [DATA_W-1:0]   o_area_number;

    logic [DATA_W-1:0]   shadow_counts    [MAX_BLOCKS];
    logic [DATA_W-1:0]   shadow_addresses [MAX_BLOCKS];
    int unsigned         shadow_live  = 0;
    logic [DATA_W-1:0]   shadow_area  = '0;
    logic [LIMIT_W-1:0]  shadow_limit = LIMIT_RESET;
    logic [LIMIT_W-1:0]  phase_limits [PHASES] =
        '{7'd64, 7'd1, 7'd20, 7'd45, 7'd0, 7'd127, 7'd64};

    t_word               pending_words[$];
    t_word               due;
    int                  mismatch_count = 0;
    int unsigned         cycle_count    = 0;

    counted_block_index_table u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_action          (i_action),
        .i_target          (i_target),
        .i_new_count       (i_new_count),
        .i_new_address     (i_new_address),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_block_limit (i_cfg_block_limit),
        .o_valid           (o_valid),
        .o_status          (o_status),
        .o_block_position  (o_block_position),
        .o_block_count     (o_block_count),
        .o_block_address   (o_block_address),
        .o_area_number     (o_area_number)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Mismatches found");
        $finish;
    end

    function automatic t_word result(t_status st, logic [POS_W-1:0] pos,
                                     logic [DATA_W-1:0] cnt, logic [DATA_W-1:0] addr,
                                     logic [DATA_W-1:0] area);
        t_word w;
        w.status  = st;
        w.pos     = pos;
        w.count   = cnt;
        w.address = addr;
        w.area    = area;
        return w;
    endfunction

    function automatic t_row word_row(t_action act, logic [DATA_W-1:0] tgt,
                                      logic [DATA_W-1:0] nc, logic [DATA_W-1:0] na,
                                      bit typed, t_word exp);
        t_row r;
        r.kind     = ROW_WORD;
        r.act      = act;
        r.target   = tgt;
        r.count    = nc;
        r.address  = na;
        r.typed    = typed;
        r.expected = exp;
        return r;
    endfunction

    function automatic t_row limit_row(logic [LIMIT_W-1:0] value);
        t_row r;
        r       = word_row(ACT_ALLOC, '0, '0, '0, 1'b0, '0);
        r.kind  = ROW_LIMIT;
        r.target = DATA_W'(value);
        return r;
    endfunction

    // Applies one word to the shadow table and returns the word the block must give.
    function automatic t_word advance_table(t_action act, logic [DATA_W-1:0] tgt,
                                            logic [DATA_W-1:0] nc, logic [DATA_W-1:0] na);
        t_word             w;
        int unsigned       cap;
        int unsigned       idx;
        logic [DATA_W-1:0] rest;
        bit                found;
        w = '0;
        w.status = ST_OK;
        case (act)
            ACT_INSERT: begin
                cap = (shadow_limit < MAX_BLOCKS) ? shadow_limit : MAX_BLOCKS;
                if (shadow_live >= cap) begin
                    w.status = ST_FULL;
                end else if (tgt > shadow_live) begin
                    w.status = ST_RANGE;
                end else begin
                    for (idx = shadow_live; idx > tgt; idx--) begin
                        shadow_counts[idx]    = shadow_counts[idx-1];
                        shadow_addresses[idx] = shadow_addresses[idx-1];
                    end
                    shadow_counts[tgt]    = '0;
                    shadow_addresses[tgt] = '0;
                    shadow_live++;
                    w.pos = tgt[POS_W-1:0];
                end
            end
            ACT_LOCATE: begin
                rest  = tgt;
                found = 1'b0;
                for (idx = 0; idx < shadow_live && !found; idx++) begin
                    if (rest < shadow_counts[idx]) begin
                        found     = 1'b1;
                        w.pos     = idx[POS_W-1:0];
                        w.count   = shadow_counts[idx];
                        w.address = shadow_addresses[idx];
                    end else begin
                        rest = rest - shadow_counts[idx];
                    end
                end
                if (!found) begin
                    w.status = ST_NOTFOUND;
                end
            end
            ACT_SET: begin
                if (tgt >= shadow_live) begin
                    w.status = ST_RANGE;
                end else begin
                    shadow_counts[tgt]    = nc;
                    shadow_addresses[tgt] = na;
                    w.pos     = tgt[POS_W-1:0];
                    w.count   = nc;
                    w.address = na;
                end
            end
            default: begin
                w.area      = shadow_area;
                shadow_area = shadow_area + 1'b1;
            end
        endcase
        return w;
    endfunction

    task automatic check_field(string name, logic [DATA_W-1:0] exp, logic [DATA_W-1:0] got);
        if (got !== exp) begin
            mismatch_count++;
            $display("%0t %s expected %h actual %h", $time, name, exp, got);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid !== 1'b0) begin
            if (pending_words.size() == 0) begin
                mismatch_count++;
                $display("%0t unexpected word expected none actual status %h", $time, o_status);
            end else begin
                due = pending_words.pop_front();
                check_field("status", DATA_W'(due.status), DATA_W'(o_status));
                check_field("block_position", DATA_W'(due.pos), DATA_W'(o_block_position));
                check_field("block_count", due.count, o_block_count);
                check_field("block_address", due.address, o_block_address);
                check_field("area_number", due.area, o_area_number);
            end
        end
    end

    task automatic issue_word(t_action act, logic [DATA_W-1:0] tgt, logic [DATA_W-1:0] nc,
                              logic [DATA_W-1:0] na, bit typed, t_word typed_word);
        t_word predicted;
        i_action      <= act;
        i_target      <= tgt;
        i_new_count   <= nc;
        i_new_address <= na;
        start         <= 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
        predicted = advance_table(act, tgt, nc, na);
        pending_words.push_back(typed ? typed_word : predicted);
    endtask

    task automatic drain_words();
        start <= 1'b0;
        while (pending_words.size() != 0 || busy !== 1'b0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic write_block_limit(logic [LIMIT_W-1:0] value);
        drain_words();
        i_cfg_block_limit <= value;
        i_cfg_valid       <= 1'b1;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_valid  <= 1'b0;
        shadow_limit = value;
    endtask

    task automatic pick_random_word(output t_action act, output logic [DATA_W-1:0] tgt,
                                    output logic [DATA_W-1:0] nc,
                                    output logic [DATA_W-1:0] na);
        int unsigned roll;
        int unsigned sel;
        int unsigned j;
        logic [63:0] base;
        logic [63:0] total;
        logic [63:0] pick;
        roll = $urandom_range(99);
        sel  = $urandom_range(99);
        na   = $urandom;
        tgt  = $urandom;
        if (sel < 10)      nc = '0;
        else if (sel < 75) nc = $urandom_range(16, 1);
        else if (sel < 88) nc = $urandom_range(1000);
        else               nc = $urandom;
        sel = $urandom_range(99);
        if (roll < 7) begin
            act = ACT_INSERT;
            if (sel < 70)      tgt = $urandom_range(shadow_live);
            else if (sel < 85) tgt = shadow_live + 1;
        end else if (roll < 52) begin
            act   = ACT_LOCATE;
            total = '0;
            base  = '0;
            sel   = (shadow_live == 0) ? 0 : $urandom_range(shadow_live - 1);
            for (j = 0; j < shadow_live; j++) begin
                if (j < sel) base += shadow_counts[j];
                total += shadow_counts[j];
            end
            roll = $urandom_range(99);
            if (roll < 60 && shadow_live != 0 && shadow_counts[sel] != 0)
                pick = base + $urandom_range(shadow_counts[sel] - 1);
            else if (roll < 75) pick = base;
            else if (roll < 85) pick = total;
            else                pick = $urandom;
            tgt = (pick > 64'hFFFF_FFFF) ? $urandom : pick[DATA_W-1:0];
        end else if (roll < 85) begin
            act = ACT_SET;
            if (sel < 80 && shadow_live != 0) tgt = $urandom_range(shadow_live - 1);
            else if (sel < 90)                tgt = shadow_live;
        end else begin
            act = ACT_ALLOC;
        end
    endtask

    initial begin
        t_row              rows[$];
        t_action           act;
        logic [DATA_W-1:0] tgt;
        logic [DATA_W-1:0] nc;
        logic [DATA_W-1:0] na;
        int unsigned       idle_pct;
        int                phase;
        int                n;

        rows.push_back(word_row(ACT_LOCATE, 0, 0, 0, 1, result(ST_NOTFOUND, 0, 0, 0, 0)));
        rows.push_back(word_row(ACT_SET, 0, 7, 7, 1, result(ST_RANGE, 0, 0, 0, 0)));
        rows.push_back(word_row(ACT_INSERT, 1, 0, 0, 1, result(ST_RANGE, 0, 0, 0, 0)));
        rows.push_back(word_row(ACT_ALLOC, 0, 0, 0, 1, result(ST_OK, 0, 0, 0, 0)));
        rows.push_back(word_row(ACT_INSERT, 0, 0, 0, 1, result(ST_OK, 0, 0, 0, 0)));
        rows.push_back(word_row(ACT_SET, 0, 5, 32'hA5A5_A5A5, 1,
                                result(ST_OK, 0, 5, 32'hA5A5_A5A5, 0)));
        rows.push_back(word_row(ACT_INSERT, 1, 0, 0, 1, result(ST_OK, 1, 0, 0, 0)));
        rows.push_back(word_row(ACT_SET, 1, '1, '1, 1, result(ST_OK, 1, '1, '1, 0)));
        rows.push_back(word_row(ACT_INSERT, 0, 0, 0, 1, result(ST_OK, 0, 0, 0, 0)));
        rows.push_back(word_row(ACT_LOCATE, 0, 0, 0, 0, '0));
        rows.push_back(word_row(ACT_LOCATE, 4, 0, 0, 0, '0));
        rows.push_back(word_row(ACT_LOCATE, 5, 0, 0, 0, '0));
        rows.push_back(word_row(ACT_LOCATE, '1, 0, 0, 0, '0));
        rows.push_back(word_row(ACT_SET, 3, 1, 1, 1, result(ST_RANGE, 0, 0, 0, 0)));
        rows.push_back(word_row(ACT_SET, '1, '1, '1, 1, result(ST_RANGE, 0, 0, 0, 0)));
        rows.push_back(word_row(ACT_INSERT, '1, 0, 0, 1, result(ST_RANGE, 0, 0, 0, 0)));
        rows.push_back(word_row(ACT_SET, 0, 2, 0, 1, result(ST_OK, 0, 2, 0, 0)));
        rows.push_back(word_row(ACT_ALLOC, '1, '1, '1, 1, result(ST_OK, 0, 0, 0, 1)));
        rows.push_back(limit_row(7'd3));
        rows.push_back(word_row(ACT_INSERT, 0, 0, 0, 1, result(ST_FULL, 0, 0, 0, 0)));
        rows.push_back(limit_row(7'd0));
        // full wins over a bad position
        rows.push_back(word_row(ACT_INSERT, 200, 0, 0, 1, result(ST_FULL, 0, 0, 0, 0)));
        rows.push_back(limit_row(7'd127));
        rows.push_back(word_row(ACT_INSERT, 3, 0, 0, 1, result(ST_OK, 3, 0, 0, 0)));
        rows.push_back(word_row(ACT_LOCATE, 7, 0, 0, 0, '0));

        phase_limits[4] = $urandom_range(127);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[r]) begin
            if (rows[r].kind == ROW_LIMIT) begin
                write_block_limit(rows[r].target[LIMIT_W-1:0]);
            end else begin
                issue_word(rows[r].act, rows[r].target, rows[r].count, rows[r].address,
                           rows[r].typed, rows[r].expected);
            end
        end

        for (phase = 0; phase < PHASES; phase++) begin
            write_block_limit(phase_limits[phase]);
            idle_pct = (phase % 3 == 0) ? 0 : (phase % 3 == 1) ? 46 : 14;
            for (n = 0; n < RANDOM_WORDS / PHASES; n++) begin
                if (n == 100) begin
                    drain_words();
                end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
                    start <= 1'b0;
                    repeat ($urandom_range(4, 1)) @(posedge i_clk);
                end
                pick_random_word(act, tgt, nc, na);
                issue_word(act, tgt, nc, na, 1'b0, '0);
            end
        end

        drain_words();
        repeat (MAX_BLOCKS + 8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

### files.f
hdl/cbit_pkg.sv
hdl/cbit_entry_ram.sv
hdl/cbit_sub_unit.sv
hdl/counted_block_index_table.sv
test/tb_counted_block_index_table.sv
